### rtl/core/rmq_pkg.sv
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion: shared package
// Widths, branch codes and the saturation helper used by the pipeline units.
// ---------------------------------------------------------------------------
package rmq_pkg;

   localparam int W = 32;

   // Quaternion branch selected from the normalized diagonal.
   typedef enum logic [3:0] {
      BR_W = 4'b0001,
      BR_X = 4'b0010,
      BR_Y = 4'b0100,
      BR_Z = 4'b1000
   } branch_type;

   localparam logic signed [W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [W-1:0] SAT_MIN = 32'sh8000_0000;

   // Saturate a 64-bit magnitude with a sign to the signed 32-bit range.
   function automatic logic signed [W-1:0] sat_mag(input logic [63:0] mag,
                                                  input logic neg);
      logic signed [W-1:0] res;
      if (neg) begin
         if (mag >= 64'h8000_0000) res = SAT_MIN;
         else res = -$signed(mag[W-1:0]);
      end else begin
         if (mag >= 64'h7FFF_FFFF) res = SAT_MAX;
         else res = $signed(mag[W-1:0]);
      end
      return res;
   endfunction

endpackage

### rtl/core/rmq_div.sv
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion: pipelined rounding divider
// Computes sat(round(num * 2^F / den)), ties away from zero, one quotient
// bit per stage, with a side payload carried alongside.
// ---------------------------------------------------------------------------
module rmq_div
   import rmq_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int NUM_W = 36,
   parameter int DEN_W = 34,
   parameter int SIDE_W = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     in_valid,
   input  logic signed [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]         in_den,
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_valid,
   output logic signed [W-1:0]      out_quo,
   output logic [SIDE_W-1:0]        out_side
);

   // Dividend is 2*|num|*2^F + den over 2*den; quotient is capped to QW bits.
   localparam int DVD_W = NUM_W + FRAC_BITS + 2;
   localparam int QW = 33;
   localparam int RW = DEN_W + 2;

   logic [DVD_W-1:0]  dvd_ff  [QW+1];
   logic [RW-1:0]     rem_ff  [QW+1];
   logic [QW-1:0]     quo_ff  [QW+1];
   logic [DEN_W:0]    den_ff  [QW+1];
   logic              neg_ff  [QW+1];
   logic              big_ff  [QW+1];
   logic              vld_ff  [QW+1];
   logic [SIDE_W-1:0] side_ff [QW+1];

   logic [NUM_W-1:0]  mag_in;
   logic [DVD_W-1:0]  dvd_in;
   logic [DVD_W-1:0]  hi_in;

   // Entry: magnitude, scaled dividend, and a check that the quotient fits.
   always_comb begin
      mag_in = in_num[NUM_W-1] ? NUM_W'(-in_num) : NUM_W'(in_num);
      dvd_in = (DVD_W'(mag_in) << (FRAC_BITS + 1)) + DVD_W'(in_den);
      hi_in  = DVD_W'(dvd_in >> QW);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= QW; i++) vld_ff[i] <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i <= QW; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // One restoring quotient bit per stage, most significant first. The bits
   // above the quotient window seed the partial remainder.
   always_ff @(posedge clock) begin
      if (enable) begin
         dvd_ff[0]  <= dvd_in;
         rem_ff[0]  <= RW'(hi_in);
         quo_ff[0]  <= '0;
         den_ff[0]  <= {in_den, 1'b0};
         neg_ff[0]  <= in_num[NUM_W-1];
         big_ff[0]  <= (hi_in >= DVD_W'({in_den, 1'b0}));
         side_ff[0] <= in_side;
         for (int i = 1; i <= QW; i++) begin
            logic [RW:0] trial;
            trial = {rem_ff[i-1], dvd_ff[i-1][QW-i]};
            if (trial >= (RW+1)'(den_ff[i-1])) begin
               rem_ff[i] <= RW'(trial - (RW+1)'(den_ff[i-1]));
               quo_ff[i] <= {quo_ff[i-1][QW-2:0], 1'b1};
            end else begin
               rem_ff[i] <= RW'(trial);
               quo_ff[i] <= {quo_ff[i-1][QW-2:0], 1'b0};
            end
            dvd_ff[i]  <= dvd_ff[i-1];
            den_ff[i]  <= den_ff[i-1];
            neg_ff[i]  <= neg_ff[i-1];
            big_ff[i]  <= big_ff[i-1];
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid = vld_ff[QW];
   assign out_side  = side_ff[QW];
   assign out_quo   = big_ff[QW] ? (neg_ff[QW] ? SAT_MIN : SAT_MAX)
                                 : sat_mag(64'(quo_ff[QW]), neg_ff[QW]);

endmodule

### rtl/core/rmq_sqrt.sv
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion: pipelined square root
// floor(sqrt(v)) of a 64-bit radicand, one result bit per stage, with a
// side payload carried alongside.
// ---------------------------------------------------------------------------
module rmq_sqrt
   import rmq_pkg::*;
#(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [63:0]       in_rad,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [31:0]       out_root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int N = 32;

   logic [63:0]       rad_ff  [N+1];
   logic [33:0]       rem_ff  [N+1];
   logic [31:0]       root_ff [N+1];
   logic              vld_ff  [N+1];
   logic [SIDE_W-1:0] side_ff [N+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= N; i++) vld_ff[i] <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i <= N; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // Restoring digit recurrence: bring down two bits, try 4r+1.
   always_ff @(posedge clock) begin
      if (enable) begin
         rad_ff[0]  <= in_rad;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
         for (int i = 1; i <= N; i++) begin
            logic [35:0] trial;
            logic [35:0] sub;
            trial = {rem_ff[i-1], rad_ff[i-1][2*(N-i)+1 -: 2]};
            sub   = {2'b00, root_ff[i-1], 2'b01};
            if (trial >= sub) begin
               rem_ff[i]  <= 34'(trial - sub);
               root_ff[i] <= {root_ff[i-1][30:0], 1'b1};
            end else begin
               rem_ff[i]  <= 34'(trial);
               root_ff[i] <= {root_ff[i-1][30:0], 1'b0};
            end
            rad_ff[i]  <= rad_ff[i-1];
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_root  = root_ff[N];
   assign out_side  = side_ff[N];

endmodule

### rtl/core/rotation_matrix_to_quaternion.sv
// ---------------------------------------------------------------------------
// Rotation matrix to quaternion (Shepperd's method)
// Normalizes a 3x3 rotation by the homogeneous corner, picks the numerically
// best branch, takes one square root and three quotients, all saturated.
// ---------------------------------------------------------------------------
//  channel | direction | tdata fields (low bit first)            | tuser
//  req     | in        | a00 a01 a02 a10 a11 a12 a20 a21 a22 a33 | -
//  rsp     | out       | quat_w quat_x quat_y quat_z ok          | -
//
// One word enters per cycle while req_tready is high; rsp_tvalid rises once the request
// word has passed through nine normalizing dividers (34 stages), one trace stage,
// a 33-stage square root, three 34-stage dividers and the output register.
// Reset clears only valid bits. A stall on rsp freezes the whole pipeline
// once a word waits in the one-word skid stage, which also drops req_tready.
// ---------------------------------------------------------------------------
module rotation_matrix_to_quaternion
   import rmq_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [319:0] req_tdata,   // a00 a01 a02 a10 a11 a12 a20 a21 a22 a33
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata    // quat_w quat_x quat_y quat_z ok, zero pad
);

   localparam logic signed [35:0] ONE = 36'sd1 <<< FRAC_BITS;

   // Pipeline advance: the skid stage is empty.
   logic            enable;
   logic            out_vld_ff;
   logic [128:0]    out_dat_ff;
   logic            skid_vld_ff;
   logic [128:0]    skid_dat_ff;
   logic            pipe_vld;
   logic [128:0]    pipe_dat;

   assign enable = !skid_vld_ff;
   assign req_tready = enable;

   // Stage A: normalize each entry by |a33|; the sign of a33 rides along.
   logic signed [31:0] a_ent [9];
   logic signed [31:0] a33;
   logic [33:0]        dmag;
   logic signed [31:0] n_q [9];
   logic [1:0]         n_side [9];
   logic               n_vld [9];

   assign a33  = req_tdata[319:288];
   assign dmag = a33[31] ? 34'(-35'(a33)) : 34'(a33);

   for (genvar g = 0; g < 9; g++) begin : g_norm
      assign a_ent[g] = req_tdata[32*g +: 32];
      rmq_div #(.FRAC_BITS(FRAC_BITS), .NUM_W(36), .DEN_W(34), .SIDE_W(2)) u_div (
         .clock(clock), .reset(reset), .enable(enable),
         .in_valid(req_tvalid && enable),
         .in_num(36'(a_ent[g])), .in_den(dmag),
         .in_side({a33 == 32'sd0, a33[31]}),
         .out_valid(n_vld[g]), .out_quo(n_q[g]), .out_side(n_side[g])
      );
   end

   // Negative corner flips the sign, saturating like a magnitude.
   logic signed [35:0] m [9];
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         logic [32:0] mg;
         mg = n_q[i][31] ? 33'(-34'(n_q[i])) : 33'(n_q[i]);
         if (n_side[0][0]) m[i] = 36'(sat_mag(64'(mg), !n_q[i][31] && n_q[i] != 0));
         else m[i] = 36'(n_q[i]);
      end
   end

   // Stage B: trace, branch choice, radicand and numerators, registered.
   logic               b_vld_ff, b_zero_ff;
   branch_type         b_br_ff;
   logic [63:0]        b_rad_ff;
   logic signed [35:0] b_num_ff [3];

   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else if (enable) b_vld_ff <= n_vld[0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         logic signed [35:0] t, rad;
         branch_type br;
         t = m[0] + m[4] + m[8];
         if (t > 0) begin
            br = BR_W; rad = t + ONE;
            b_num_ff[0] <= m[5] - m[7]; b_num_ff[1] <= m[6] - m[2];
            b_num_ff[2] <= m[1] - m[3];
         end else if (m[0] > m[4] && m[0] > m[8]) begin
            br = BR_X; rad = ONE + m[0] - m[4] - m[8];
            b_num_ff[0] <= m[5] - m[7]; b_num_ff[1] <= m[3] + m[1];
            b_num_ff[2] <= m[6] + m[2];
         end else if (m[4] > m[8]) begin
            br = BR_Y; rad = ONE + m[4] - m[0] - m[8];
            b_num_ff[0] <= m[6] - m[2]; b_num_ff[1] <= m[3] + m[1];
            b_num_ff[2] <= m[7] + m[5];
         end else begin
            br = BR_Z; rad = ONE + m[8] - m[0] - m[4];
            b_num_ff[0] <= m[1] - m[3]; b_num_ff[1] <= m[6] + m[2];
            b_num_ff[2] <= m[7] + m[5];
         end
         b_br_ff   <= br;
         b_zero_ff <= n_side[0][1];
         b_rad_ff  <= (rad > 0) ? (64'(rad) << FRAC_BITS) : 64'd0;
      end
   end

   // Stage C: square root with branch and numerators carried alongside.
   localparam int SQ_SIDE = 1 + 4 + 108;
   logic               c_vld;
   logic [31:0]        c_root;
   logic [SQ_SIDE-1:0] c_side;

   rmq_sqrt #(.SIDE_W(SQ_SIDE)) u_sqrt (
      .clock(clock), .reset(reset), .enable(enable), .in_valid(b_vld_ff),
      .in_rad(b_rad_ff),
      .in_side({b_zero_ff, b_br_ff, b_num_ff[2], b_num_ff[1], b_num_ff[0]}),
      .out_valid(c_vld), .out_root(c_root), .out_side(c_side)
   );

   // Stage D: three quotients num / 2r; zero root saturates by sign.
   localparam int DQ_SIDE = 1 + 4 + 32 + 6;
   logic signed [31:0] d_q [3];
   logic [DQ_SIDE-1:0] d_side [3];
   logic               d_vld [3];
   logic [31:0]        half;

   assign half = 32'((33'(c_root) + 33'd1) >> 1);

   for (genvar g = 0; g < 3; g++) begin : g_comp
      logic signed [35:0] num;
      assign num = c_side[36*g +: 36];
      rmq_div #(.FRAC_BITS(FRAC_BITS), .NUM_W(36), .DEN_W(34),
                .SIDE_W(DQ_SIDE)) u_div (
         .clock(clock), .reset(reset), .enable(enable), .in_valid(c_vld),
         .in_num(num), .in_den((c_root == 0) ? 34'd2 : {1'b0, c_root, 1'b0}),
         .in_side({c_side[112:108], half, c_root == 0, num > 0, num < 0,
                   3'b000}),
         .out_valid(d_vld[g]), .out_quo(d_q[g]), .out_side(d_side[g])
      );
   end

   // Final assembly of the result word.
   always_comb begin
      logic signed [31:0] o [3];
      logic signed [31:0] sel;
      branch_type br;
      logic zero;
      zero = d_side[0][42];
      br   = branch_type'(d_side[0][41:38]);
      sel  = d_side[0][37:6];
      for (int i = 0; i < 3; i++) begin
         if (d_side[i][5]) o[i] = d_side[i][4] ? SAT_MAX :
                                  (d_side[i][3] ? SAT_MIN : 32'sd0);
         else o[i] = d_q[i];
      end
      case (br)
         BR_W:    pipe_dat = {1'b1, o[2], o[1], o[0], sel};
         BR_X:    pipe_dat = {1'b1, o[2], o[1], sel, o[0]};
         BR_Y:    pipe_dat = {1'b1, o[2], sel, o[1], o[0]};
         default: pipe_dat = {1'b1, sel, o[2], o[1], o[0]};
      endcase
      if (zero) pipe_dat = '0;
      pipe_vld = d_vld[0];
   end

   // Output register with one skid word behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (!out_vld_ff || rsp_tready) begin
            out_vld_ff  <= skid_vld_ff || pipe_vld;
            skid_vld_ff <= 1'b0;
         end else if (pipe_vld && enable) begin
            skid_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || rsp_tready) begin
         out_dat_ff <= skid_vld_ff ? skid_dat_ff : pipe_dat;
      end else if (pipe_vld && enable) begin
         skid_dat_ff <= pipe_dat;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {7'd0, out_dat_ff};

endmodule
